[rtl/amap_pkg.sv]
// ----------------------------------------------------------------------------
// Analog axis mapper package
// Shared widths, register indexes, flag positions and curve codes.
// ----------------------------------------------------------------------------
package amap_pkg;

    localparam int MV_W   = 16;
    localparam int OUT_W  = 24;
    localparam int IDX_W  = 4;
    localparam int DATA_W = 16;

    localparam logic [15:0] Q15_ONE = 16'd32768;
    localparam logic [23:0] REL_LIM = 24'd127;

    typedef logic [IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MID      = 4'd0;
    localparam t_cfg_idx CFG_FULL     = 4'd1;
    localparam t_cfg_idx CFG_DEADZONE = 4'd2;
    localparam t_cfg_idx CFG_OUT_MIN  = 4'd3;
    localparam t_cfg_idx CFG_OUT_MAX  = 4'd4;
    localparam t_cfg_idx CFG_MUL      = 4'd5;
    localparam t_cfg_idx CFG_DIV      = 4'd6;
    localparam t_cfg_idx CFG_FLAGS    = 4'd7;

    localparam int FLG_EN  = 0;
    localparam int FLG_INV = 1;
    localparam int FLG_REL = 2;

    localparam logic [1:0] CURVE_SOFT = 2'd1;
    localparam logic [1:0] CURVE_AGGR = 2'd2;

    // Stage layout of the pipeline
    localparam int ND   = 16;             // norm divider steps
    localparam int NQ   = 16;             // square root steps
    localparam int NV   = 24;             // scale divider steps
    localparam int D0   = 2;
    localparam int Q0   = D0 + ND;
    localparam int M1   = Q0 + NQ;
    localparam int M2   = M1 + 1;
    localparam int M3   = M2 + 1;
    localparam int V0   = M3 + 1;
    localparam int OST  = V0 + NV;
    localparam int NST  = OST + 1;

    typedef struct packed {
        logic v;
        logic neg;
        logic zero;
    } t_ctl;

endpackage

[rtl/analog_axis_deadzone_curve_mapper_core.sv]
// Throughput: one item per cycle; the pipeline advances as a whole and holds
// only while the output item is stalled.
// Reset: synchronous, active low; clears valid bits and loads register
// defaults (mid 1650, travel 1650, deadzone 100, range 0..127, scale 1/1).
// ----------------------------------------------------------------------------
// Analog axis deadzone and response curve mapper
// Deadzone, Q15 normalize by pipelined divider, linear/soft/aggressive curve,
// output range mapping, post scale by pipelined divider, sign and clamp.
// ----------------------------------------------------------------------------
module analog_axis_deadzone_curve_mapper_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [amap_pkg::MV_W-1:0]     i_sample_mv,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [amap_pkg::OUT_W-1:0] o_report_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [amap_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [amap_pkg::DATA_W-1:0]   i_cfg_data
);
    import amap_pkg::*;

    // configuration
    logic [15:0] r_mid, r_full, r_dz;
    logic [14:0] r_omin, r_omax;
    logic [7:0]  r_mul, r_div;
    logic [4:0]  r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= 16'd1650;
            r_full  <= 16'd1650;
            r_dz    <= 16'd100;
            r_omin  <= 15'd0;
            r_omax  <= 15'd127;
            r_mul   <= 8'd1;
            r_div   <= 8'd1;
            r_flags <= 5'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MID:      r_mid   <= i_cfg_data;
                CFG_FULL:     r_full  <= i_cfg_data;
                CFG_DEADZONE: r_dz    <= i_cfg_data;
                CFG_OUT_MIN:  r_omin  <= i_cfg_data[14:0];
                CFG_OUT_MAX:  r_omax  <= i_cfg_data[14:0];
                CFG_MUL:      r_mul   <= i_cfg_data[7:0];
                CFG_DIV:      r_div   <= i_cfg_data[7:0];
                CFG_FLAGS:    r_flags <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // derived constants of the current setup
    logic [15:0] rng, span, omin16;
    logic [7:0]  mulv, divv;
    always_comb begin
        rng    = (r_full > r_dz) ? (r_full - r_dz) : 16'd1;
        omin16 = {1'b0, r_omin};
        span   = (r_omax > r_omin) ? ({1'b0, r_omax} - omin16) : 16'd1;
        mulv   = (r_mul == 8'd0) ? 8'd1 : r_mul;
        divv   = (r_div == 8'd0) ? 8'd1 : r_div;
    end

    logic en;
    t_ctl r_ctl [NST];
    t_ctl n_ctl [NST];

    assign en      = !r_ctl[OST].v || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_ctl[OST].v;

    // front: distance and deadzone
    logic [15:0] r_amt, n_amt, r_push, n_push;
    logic        neg0, zero1;
    logic [15:0] amt_dz;

    // pipeline payload
    logic [15:0] r_d_rem [ND], n_d_rem [ND];
    logic [15:0] r_d_q   [ND], n_d_q   [ND];
    logic [30:0] r_q_v   [NQ], n_q_v   [NQ];
    logic [30:0] r_q_r   [NQ], n_q_r   [NQ];
    logic [15:0] r_q_n   [NQ], n_q_n   [NQ];
    logic [15:0] r_q_s   [NQ], n_q_s   [NQ];
    logic [31:0] r_m1, n_m1;
    logic [15:0] r_m2, n_m2;
    logic [23:0] r_m3, n_m3;
    logic [7:0]  r_v_rem [NV], n_v_rem [NV];
    logic [23:0] r_v_q   [NV], n_v_q   [NV];
    logic [23:0] r_v_d   [NV], n_v_d   [NV];
    logic [23:0] r_out, n_out;

    always_comb begin
        neg0  = i_sample_mv < r_mid;
        n_amt = neg0 ? (r_mid - i_sample_mv) : (i_sample_mv - r_mid);
        zero1 = !r_flags[FLG_EN] || (r_amt <= r_dz);
        amt_dz = r_amt - r_dz;
        n_push = (amt_dz > rng) ? rng : amt_dz;
        n_ctl[0] = '{v: i_valid, neg: neg0, zero: 1'b0};
        n_ctl[1] = '{v: r_ctl[0].v, neg: r_ctl[0].neg, zero: zero1};
        for (int k = 2; k < NST; k++) begin
            n_ctl[k] = r_ctl[k-1];
        end
    end

    // norm = push * 2^15 / range, one quotient bit a stage
    always_comb begin
        logic [16:0] t;
        logic [15:0] qi;
        logic        b;
        for (int k = 0; k < ND; k++) begin
            if (k == 0) begin
                t  = {1'b0, r_push};
                qi = 16'd0;
            end else begin
                t  = {r_d_rem[k-1], 1'b0};
                qi = r_d_q[k-1];
            end
            b = (t >= {1'b0, rng});
            n_d_rem[k] = b ? 16'(t - {1'b0, rng}) : t[15:0];
            n_d_q[k]   = {qi[14:0], b};
        end
    end

    // soft curve: isqrt(norm * 2^15), one root step a stage; square rides along
    always_comb begin
        logic [30:0] v, r, bb;
        logic [31:0] sq;
        for (int k = 0; k < NQ; k++) begin
            bb = 31'(1) << (30 - 2 * k);
            if (k == 0) begin
                v  = {r_d_q[ND-1], 15'd0};
                r  = 31'd0;
                sq = r_d_q[ND-1] * r_d_q[ND-1];
                n_q_n[k] = r_d_q[ND-1];
                n_q_s[k] = sq[30:15];
            end else begin
                v  = r_q_v[k-1];
                r  = r_q_r[k-1];
                sq = 32'd0;
                n_q_n[k] = r_q_n[k-1];
                n_q_s[k] = r_q_s[k-1];
            end
            if ({1'b0, v} >= ({1'b0, r} + {1'b0, bb})) begin
                n_q_v[k] = v - (r + bb);
                n_q_r[k] = (r >> 1) + bb;
            end else begin
                n_q_v[k] = v;
                n_q_r[k] = r >> 1;
            end
        end
    end

    // curve select, range map and post multiply
    always_comb begin
        logic [15:0] curved;
        case (r_flags[4:3])
            CURVE_SOFT: curved = r_q_r[NQ-1][15:0];
            CURVE_AGGR: curved = r_q_s[NQ-1];
            default:    curved = r_q_n[NQ-1];
        endcase
        n_m1 = span * curved;
        n_m2 = omin16 + r_m1[30:15];
        n_m3 = r_m2 * mulv;
    end

    // post divide, one quotient bit a stage
    always_comb begin
        logic [8:0]  t;
        logic [23:0] d, qi;
        logic        b;
        for (int k = 0; k < NV; k++) begin
            if (k == 0) begin
                d  = r_m3;
                qi = 24'd0;
                t  = {8'd0, d[NV-1]};
            end else begin
                d  = r_v_d[k-1];
                qi = r_v_q[k-1];
                t  = {r_v_rem[k-1], d[NV-1-k]};
            end
            b = (t >= {1'b0, divv});
            n_v_rem[k] = b ? 8'(t - {1'b0, divv}) : t[7:0];
            n_v_q[k]   = {qi[22:0], b};
            n_v_d[k]   = d;
        end
    end

    // sign, invert and relative clamp
    always_comb begin
        logic [23:0] mag;
        mag = r_v_q[NV-1];
        if (r_flags[FLG_REL] && (mag > REL_LIM)) begin
            mag = REL_LIM;
        end
        if (r_ctl[OST-1].zero) begin
            n_out = 24'd0;
        end else if (r_ctl[OST-1].neg ^ r_flags[FLG_INV]) begin
            n_out = 24'd0 - mag;
        end else begin
            n_out = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (en) begin
            for (int k = 0; k < NST; k++) begin
                r_ctl[k] <= n_ctl[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_amt  <= n_amt;
            r_push <= n_push;
            for (int k = 0; k < ND; k++) begin
                r_d_rem[k] <= n_d_rem[k];
                r_d_q[k]   <= n_d_q[k];
            end
            for (int k = 0; k < NQ; k++) begin
                r_q_v[k] <= n_q_v[k];
                r_q_r[k] <= n_q_r[k];
                r_q_n[k] <= n_q_n[k];
                r_q_s[k] <= n_q_s[k];
            end
            r_m1 <= n_m1;
            r_m2 <= n_m2;
            r_m3 <= n_m3;
            for (int k = 0; k < NV; k++) begin
                r_v_rem[k] <= n_v_rem[k];
                r_v_q[k]   <= n_v_q[k];
                r_v_d[k]   <= n_v_d[k];
            end
            r_out <= n_out;
        end
    end

    assign o_report_value = r_out;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output item pending");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_ctl[1]) && $stable(r_amt))
        else $error("pipeline moved while stalled");

    a_zero_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[OST].v && r_ctl[OST].zero |-> r_out == 24'd0)
        else $error("deadzone item gave nonzero report");

endmodule

[verif/tb_analog_axis_deadzone_curve_mapper_core.sv]
// ----------------------------------------------------------------------------
// Analog axis mapper testbench
// Feeds millivolt samples through the deadzone/curve mapper under a series of
// register settings, predicts each report value in the bench and compares it
// with what the block returns, under random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_analog_axis_deadzone_curve_mapper_core;
    import amap_pkg::*;

    localparam logic [1:0] CURVE_LIN = 2'd0;
    localparam logic [1:0] CURVE_ALT = 2'd3;
    localparam t_cfg_idx   CFG_NONE  = 4'd9;
    localparam int         RUN_LIMIT = 400000;
    localparam int         STRETCH   = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_vld = 1'b0;
    logic        o_stall;
    logic [15:0] in_smp = '0;
    logic        o_valid;
    logic        out_stl = 1'b0;
    logic signed [OUT_W-1:0] o_report_value;
    logic        cfg_vld;
    logic        o_cfg_ready;
    t_cfg_idx    cfg_idx;
    logic [15:0] cfg_dat;

    analog_axis_deadzone_curve_mapper_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_vld),
        .o_stall        (o_stall),
        .i_sample_mv    (in_smp),
        .o_valid        (o_valid),
        .i_stall        (out_stl),
        .o_report_value (o_report_value),
        .i_cfg_valid    (cfg_vld),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_idx),
        .i_cfg_data     (cfg_dat)
    );

    // mapper settings as the bench sees them
    logic [15:0] mid, travel, dzone;
    logic [14:0] omin, omax;
    logic [7:0]  smul, sdiv;
    logic [4:0]  flags;

    logic [15:0]             pend_samples[$];
    logic signed [OUT_W-1:0] exp_reports[$];
    int  errors = 0;
    int  cycles = 0;
    logic in_took = 0, out_took = 0;
    int  in_gap = 0, out_wait = 0;
    bit  no_idle = 0;
    bit  stretch_on = 0;
    int  stretch_cnt = 0;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    function automatic int unsigned isqrt32(int unsigned v);
        int unsigned root, bit_w;
        root = 0;
        bit_w = 32'd1 << 30;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= root + bit_w) begin
                v -= root + bit_w;
                root = (root >> 1) + bit_w;
            end else begin
                root >>= 1;
            end
            bit_w >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [OUT_W-1:0] predict_report(logic [15:0] mv);
        int unsigned amt, rng, push, nrm, crv, hi, mag, m, d;
        logic neg;
        int res;
        if (!flags[FLG_EN]) return '0;
        neg = mv < mid;
        amt = neg ? 32'(mid) - 32'(mv) : 32'(mv) - 32'(mid);
        if (amt <= dzone) return '0;
        rng  = travel > dzone ? 32'(travel) - 32'(dzone) : 1;
        push = amt - dzone;
        if (push > rng) push = rng;
        nrm = (push * 32768) / rng;
        if (nrm > 32768) nrm = 32768;
        case (flags[4:3])
            CURVE_SOFT: crv = isqrt32(nrm * 32768);
            CURVE_AGGR: crv = (nrm * nrm) / 32768;
            default:    crv = nrm;
        endcase
        if (crv > 32768) crv = 32768;
        hi  = omax > omin ? 32'(omax) : 32'(omin) + 1;
        mag = omin + ((hi - omin) * crv) / 32768;
        m   = smul == 0 ? 1 : smul;
        d   = sdiv == 0 ? 1 : sdiv;
        mag = (mag * m) / d;
        res = int'(mag);
        if (neg) res = -res;
        if (flags[FLG_INV]) res = -res;
        if (flags[FLG_REL]) begin
            if (res > 127) res = 127;
            else if (res < -127) res = -127;
        end
        return res[OUT_W-1:0];
    endfunction

    // sample handshakes, track settings, predict and compare
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        if (!i_rst_n) begin
            mid <= 16'd1650; travel <= 16'd1650; dzone <= 16'd100;
            omin <= 15'd0; omax <= 15'd127; smul <= 8'd1; sdiv <= 8'd1;
            flags <= 5'd1;
        end else if (cfg_vld && o_cfg_ready) begin
            case (cfg_idx)
                CFG_MID:      mid    <= cfg_dat;
                CFG_FULL:     travel <= cfg_dat;
                CFG_DEADZONE: dzone  <= cfg_dat;
                CFG_OUT_MIN:  omin   <= cfg_dat[14:0];
                CFG_OUT_MAX:  omax   <= cfg_dat[14:0];
                CFG_MUL:      smul   <= cfg_dat[7:0];
                CFG_DIV:      sdiv   <= cfg_dat[7:0];
                CFG_FLAGS:    flags  <= cfg_dat[4:0];
                default: ;
            endcase
        end
        in_took  <= i_rst_n && in_vld && !o_stall;
        out_took <= i_rst_n && o_valid && !out_stl;
        if (i_rst_n && in_vld && !o_stall)
            exp_reports.push_back(predict_report(in_smp));
        if (i_rst_n && o_valid && !out_stl) begin
            if (exp_reports.size() == 0) begin
                $display("%0t: unexpected report_value %0d", $time, o_report_value);
                errors++;
            end else begin
                if (o_report_value !== exp_reports[0]) begin
                    $display("%0t: report_value expected %0d actual %0d",
                             $time, exp_reports[0], o_report_value);
                    errors++;
                end
                void'(exp_reports.pop_front());
            end
        end
    end

    // sample driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_vld <= 1'b0;
        end else if (in_vld && !in_took) begin
            // hold the stalled item
        end else if (in_gap != 0) begin
            in_gap <= in_gap - 1;
            in_vld <= 1'b0;
        end else if (pend_samples.size() != 0) begin
            in_vld <= 1'b1;
            in_smp <= pend_samples.pop_front();
            in_gap <= no_idle ? 0 : $urandom_range(0, 15);
        end else begin
            in_vld <= 1'b0;
        end
    end

    // report receiver
    always @(negedge i_clk) begin
        int w;
        w = out_took ? (no_idle ? 0 : $urandom_range(0, 15)) : out_wait;
        if (stretch_on && stretch_cnt < STRETCH) begin
            stretch_cnt <= stretch_cnt + 1;
            out_stl <= 1'b1;
            out_wait <= w;
        end else if (w != 0) begin
            out_stl <= 1'b1;
            out_wait <= w - 1;
        end else begin
            out_stl <= 1'b0;
            out_wait <= 0;
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] data);
        @(negedge i_clk);
        cfg_vld <= 1'b1;
        cfg_idx <= idx;
        cfg_dat <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_vld <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (!(pend_samples.size() == 0 && !in_vld && exp_reports.size() == 0));
    endtask

    // mostly around the centre, some full range
    task automatic add_samples(int count);
        int k, off;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                pend_samples.push_back(16'($urandom));
            end else begin
                off = $urandom_range(0, 32'(travel) + 200);
                pend_samples.push_back($urandom_range(0, 1) ? 16'(mid + off)
                                                            : 16'(mid - off));
            end
        end
    endtask

    task automatic random_settings();
        logic [4:0] f;
        cfg_write(CFG_MID, $urandom_range(0, 7) == 0 ? 16'($urandom)
                                                     : 16'($urandom_range(500, 3000)));
        cfg_write(CFG_FULL, $urandom_range(0, 7) == 0 ? 16'($urandom)
                                                      : 16'($urandom_range(1, 3000)));
        cfg_write(CFG_DEADZONE, $urandom_range(0, 7) == 0 ? 16'($urandom)
                                                          : 16'($urandom_range(0, 300)));
        cfg_write(CFG_OUT_MIN, $urandom_range(0, 1) ? 16'd0 : 16'($urandom));
        cfg_write(CFG_OUT_MAX, 16'($urandom));
        cfg_write(CFG_MUL, 16'($urandom_range(0, 255)));
        cfg_write(CFG_DIV, 16'($urandom_range(0, 255)));
        f = 5'($urandom);
        if ($urandom_range(0, 7) != 0) f[FLG_EN] = 1'b1;
        cfg_write(CFG_FLAGS, {11'd0, f});
    endtask

    initial begin
        int ph;
        i_rst_n = 1'b0;
        cfg_vld = 1'b0;
        cfg_idx = CFG_MID;
        cfg_dat = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults: extremes, centre, deadzone edges, full travel and beyond
        pend_samples = '{16'd0, 16'hFFFF, 16'd1650, 16'd1750, 16'd1751, 16'd1550,
                         16'd1549, 16'd3200, 16'd3300, 16'd100, 16'd5000, 16'd1800};
        wait_drained();

        // extremes: zero scale, inverted range, widest magnitude, soft curve
        cfg_write(CFG_MID, 16'd0);
        cfg_write(CFG_FULL, 16'hFFFF);
        cfg_write(CFG_DEADZONE, 16'd0);
        cfg_write(CFG_OUT_MIN, 16'h7FFF);
        cfg_write(CFG_OUT_MAX, 16'd0);
        cfg_write(CFG_MUL, 16'd255);
        cfg_write(CFG_DIV, 16'd0);
        cfg_write(CFG_FLAGS, {11'd0, CURVE_SOFT, 3'b001});
        cfg_write(CFG_NONE, 16'hFFFF);  // out of range index, no effect
        pend_samples = '{16'd0, 16'd1, 16'hFFFF, 16'h8000};
        wait_drained();

        // full travel inside deadzone, aggressive, invert + relative clamp
        cfg_write(CFG_MID, 16'hFFFF);
        cfg_write(CFG_FULL, 16'd10);
        cfg_write(CFG_DEADZONE, 16'd20);
        cfg_write(CFG_OUT_MIN, 16'd0);
        cfg_write(CFG_OUT_MAX, 16'h7FFF);
        cfg_write(CFG_MUL, 16'd0);
        cfg_write(CFG_FLAGS, {11'd0, CURVE_AGGR, 3'b111});
        pend_samples = '{16'd0, 16'hFFEB, 16'hFFEA, 16'hFFFF};
        wait_drained();

        // unused curve code, then axis disabled
        cfg_write(CFG_FLAGS, {11'd0, CURVE_ALT, 3'b011});
        pend_samples = '{16'd0, 16'hFFE0};
        wait_drained();
        cfg_write(CFG_FLAGS, {11'd0, CURVE_LIN, 3'b110});
        pend_samples = '{16'd0, 16'hFFFF};
        wait_drained();

        for (ph = 0; ph < 10; ph++) begin
            random_settings();
            no_idle = (ph % 4 == 1);
            if (ph == 3) begin
                stretch_on = 1;
            end
            add_samples(82);
            wait_drained();
        end

        repeat (80) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
